FILE: design/stok_pkg.sv
// stok_pkg: token kinds, scan modes, lexeme table and character classes
// shared by the source tokenizer modules; no dependencies
package stok_pkg;

    // token kinds
    localparam logic [4:0] KIND_INT    = 5'd19;
    localparam logic [4:0] KIND_IDENT  = 5'd20;
    localparam logic [4:0] KIND_STRING = 5'd21;
    localparam logic [4:0] KIND_CHAR   = 5'd22;
    localparam logic [4:0] KIND_ERROR  = 5'd23;
    localparam logic [4:0] KIND_NONE   = 5'd24;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SYMBOL = 2'd1;
    localparam logic [1:0] ERR_UNTERM = 2'd2;

    // characters with a role of their own
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

    // scanner modes
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_IDENT   = 5'b00100,
        MODE_NUMBER  = 5'b01000,
        MODE_STRING  = 5'b10000
    } mode_t;

    // lexeme table in priority order; text is stored reversed so that
    // byte j of the lexeme sits at bits [8j+7:8j]
    localparam int LEX_COUNT = 20;
    localparam int LEX_MAX   = 5;

    localparam logic [39:0] LEX_TEXT [LEX_COUNT] = '{
        "fed", "cnuf", "fi", "esle", "elihw",
        "(", ")", "{", "}", "=:", "-<", "$", ",", ";",
        "+", "-", "*", "/", "<", "="
    };
    localparam logic [2:0] LEX_LEN [LEX_COUNT] = '{
        3'd3, 3'd4, 3'd2, 3'd4, 3'd5,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };
    localparam logic LEX_KEY [LEX_COUNT] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
    };
    localparam logic [4:0] LEX_KIND [LEX_COUNT] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4,
        5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
        5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd25
    };

    function automatic logic is_alpha(input logic [7:0] ch);
        logic [7:0] lc;
        lc = ch | 8'h20;
        return (lc >= 8'h61) && (lc <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] ch);
        return is_alpha(ch) || is_digit(ch) || (ch == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_TAB) || (ch == CH_LF);
    endfunction

    // one decimal digit into the accumulator, saturating
    function automatic logic [30:0] acc_step(input logic [30:0] acc, input logic [7:0] ch);
        logic [34:0] prod;
        logic [7:0]  dig;
        dig  = ch - CH_ZERO;
        prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 35'(dig);
        return (prod > 35'(INT_MAX)) ? INT_MAX : prod[30:0];
    endfunction

endpackage

FILE: design/stok_queue.sv
// stok_queue: two-entry item queue with valid/stall on both sides
// no package dependencies
module stok_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_stall,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_stall,
    output logic [W-1:0] pop_data
);
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic [W-1:0] entry0_reg;
    logic [W-1:0] entry1_reg;
    logic         push;
    logic         pop;
    logic [1:0]   wr_slot;

    // handshakes
    assign push_stall = (count_reg == 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry0_reg;
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;
    assign wr_slot    = count_reg - {1'b0, pop};

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entries, head always in slot 0
    always_ff @(posedge clk)
    begin
        if (pop && count_reg == 2'd2)
        begin
            entry0_reg <= entry1_reg;
        end
        if (push)
        begin
            if (wr_slot == 2'd0)
            begin
                entry0_reg <= push_data;
            end
            else
            begin
                entry1_reg <= push_data;
            end
        end
    end
endmodule

FILE: design/stok_scan.sv
// stok_scan: lookahead window and scanner, one scan step per cycle unless stalled,
// with a one-result hold stage that marks the last result of an item; uses stok_pkg
module stok_scan #(
    parameter int POSITION_BITS = 16,
    parameter int WINDOW_DEPTH  = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic [7:0]               item_byte,
    input  logic                     item_eot,
    output logic                     item_pop,
    input  logic                     res_ready,
    output logic                     res_push,
    output logic [4:0]               res_kind,
    output logic [POSITION_BITS-1:0] res_sl,
    output logic [POSITION_BITS-1:0] res_sc,
    output logic [POSITION_BITS-1:0] res_el,
    output logic [POSITION_BITS-1:0] res_ec,
    output logic [30:0]              res_val,
    output logic [7:0]               res_ch,
    output logic [1:0]               res_err,
    output logic                     res_last
);
    import stok_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int DW = WINDOW_DEPTH * 8;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [PB-1:0] POS_MAX   = '1;
    localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_DEPTH);

    typedef struct packed {
        logic [4:0]    kind;
        logic [PB-1:0] sl;
        logic [PB-1:0] sc;
        logic [PB-1:0] el;
        logic [PB-1:0] ec;
        logic [30:0]   val;
        logic [7:0]    ch;
        logic [1:0]    err;
    } res_t;

    function automatic logic [PB-1:0] sat_add(input logic [PB-1:0] v, input logic [2:0] n);
        logic [PB:0] s;
        s = {1'b0, v} + (PB+1)'(n);
        return s[PB] ? POS_MAX : s[PB-1:0];
    endfunction

    // scanner state
    logic [DW-1:0]  win_reg,   win_next;
    logic [FW-1:0]  fill_reg,  fill_next;
    mode_t          mode_reg,  mode_next;
    logic [PB-1:0]  line_reg,  line_next;
    logic [PB-1:0]  col_reg,   col_next;
    logic [PB-1:0]  tsl_reg,   tsl_next;
    logic [PB-1:0]  tsc_reg,   tsc_next;
    logic [PB-1:0]  lastl_reg, lastl_next;
    logic [PB-1:0]  lastc_reg, lastc_next;
    logic [30:0]    acc_reg,   acc_next;
    logic           err_reg;
    // item control
    logic           act_reg;
    logic           eot_reg;
    logic           any_reg;
    // result hold stage
    res_t           hold_reg;
    logic           hold_v_reg;
    logic           hold_fin_reg;

    logic           step_en;
    logic           push_b;
    logic           eot_v;
    logic           any_v;
    logic [DW-1:0]  wv;
    logic [FW-1:0]  fv;
    logic [7:0]     c;
    logic [7:0]     c1;
    logic           scan;
    logic           lex_hit;
    logic [4:0]     lex_idx;
    logic           m;
    logic [2:0]     k;
    logic           drop;
    logic           err_now;
    logic           fin_step;
    logic           restart;
    logic           res_v;
    res_t           res;
    logic           done;

    // working view of the window with this cycle's byte written in
    assign step_en  = !hold_fin_reg && res_ready && (act_reg || item_valid);
    assign item_pop = step_en && !act_reg;
    assign push_b   = !act_reg && !err_reg && (fill_reg != FILL_FULL);
    assign eot_v    = act_reg ? eot_reg : item_eot;
    assign any_v    = act_reg && any_reg;
    assign wv       = push_b ? (win_reg | (DW'(item_byte) << {fill_reg, 3'b000})) : win_reg;
    assign fv       = push_b ? (fill_reg + 1'b1) : fill_reg;
    assign c        = wv[7:0];
    assign c1       = wv[15:8];
    assign scan     = (fv == FILL_FULL) || (eot_v && fv != '0);

    // lexeme match, first entry of the table wins
    always_comb
    begin
        m       = 1'b0;
        lex_hit = 1'b0;
        lex_idx = '0;
        for (int l = LEX_COUNT - 1; l >= 0; l--)
        begin
            m = (FW'(LEX_LEN[l]) <= fv);
            for (int j = 0; j < LEX_MAX; j++)
            begin
                if (3'(j) < LEX_LEN[l] && wv[j*8 +: 8] != LEX_TEXT[l][j*8 +: 8])
                begin
                    m = 1'b0;
                end
            end
            if (LEX_KEY[l] && FW'(LEX_LEN[l]) < fv && is_alpha(wv[LEX_LEN[l]*8 +: 8]))
            begin
                m = 1'b0;
            end
            if (m)
            begin
                lex_hit = 1'b1;
                lex_idx = 5'(l);
            end
        end
    end

    // one scan step
    always_comb
    begin
        k         = 3'd0;
        drop      = 1'b0;
        err_now   = 1'b0;
        fin_step  = 1'b0;
        restart   = 1'b0;
        res_v     = 1'b0;
        res       = '0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        tsl_next  = tsl_reg;
        tsc_next  = tsc_reg;
        if (!act_reg && err_reg)
        begin
            drop = 1'b1;
        end
        else if (scan)
        begin
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                    k = 3'd1;
                    if (c == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_STRING:
                begin
                    k     = 3'd1;
                    res_v = 1'b1;
                    if (c == CH_QUOTE)
                    begin
                        res       = '{KIND_STRING, tsl_reg, tsc_reg, line_reg, col_reg,
                                      31'd0, 8'd0, ERR_NONE};
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        res = '{KIND_CHAR, line_reg, col_reg, line_reg, col_reg,
                                31'd0, c, ERR_NONE};
                    end
                end
                MODE_IDENT:
                begin
                    res_v = 1'b1;
                    if (is_ident_char(c))
                    begin
                        k   = 3'd1;
                        res = '{KIND_CHAR, line_reg, col_reg, line_reg, col_reg,
                                31'd0, c, ERR_NONE};
                    end
                    else
                    begin
                        // pending identifier closes, head byte rescanned next step
                        res       = '{KIND_IDENT, tsl_reg, tsc_reg, lastl_reg, lastc_reg,
                                      31'd0, 8'd0, ERR_NONE};
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(c))
                    begin
                        k        = 3'd1;
                        acc_next = acc_step(acc_reg, c);
                    end
                    else
                    begin
                        res_v     = 1'b1;
                        res       = '{KIND_INT, tsl_reg, tsc_reg, lastl_reg, lastc_reg,
                                      acc_reg, 8'd0, ERR_NONE};
                        mode_next = MODE_IDLE;
                    end
                end
                // idle and unused codes
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (c == CH_SLASH && fv >= FW'(2) && c1 == CH_SLASH)
                    begin
                        k         = 3'd2;
                        mode_next = MODE_COMMENT;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        k         = 3'd1;
                        tsl_next  = line_reg;
                        tsc_next  = col_reg;
                        mode_next = MODE_STRING;
                    end
                    else if (is_digit(c))
                    begin
                        k         = 3'd1;
                        tsl_next  = line_reg;
                        tsc_next  = col_reg;
                        acc_next  = acc_step(31'd0, c);
                        mode_next = MODE_NUMBER;
                    end
                    else if (lex_hit)
                    begin
                        k        = LEX_LEN[lex_idx];
                        tsl_next = line_reg;
                        tsc_next = col_reg;
                        res_v    = 1'b1;
                        res      = '{LEX_KIND[lex_idx], line_reg, col_reg, line_reg,
                                     sat_add(col_reg, LEX_LEN[lex_idx] - 3'd1),
                                     31'd0, 8'd0, ERR_NONE};
                    end
                    else if (is_alpha(c) || c == CH_UNDER)
                    begin
                        k         = 3'd1;
                        tsl_next  = line_reg;
                        tsc_next  = col_reg;
                        res_v     = 1'b1;
                        res       = '{KIND_CHAR, line_reg, col_reg, line_reg, col_reg,
                                      31'd0, c, ERR_NONE};
                        mode_next = MODE_IDENT;
                    end
                    else if (is_space(c))
                    begin
                        k = 3'd1;
                    end
                    else
                    begin
                        err_now = 1'b1;
                        res_v   = 1'b1;
                        res     = '{KIND_ERROR, line_reg, col_reg, line_reg, col_reg,
                                    31'd0, 8'd0, ERR_SYMBOL};
                    end
                end
            endcase
        end
        else if (eot_v)
        begin
            // end of text: open string is an error, else close, restart positions
            fin_step = 1'b1;
            if (mode_reg == MODE_STRING)
            begin
                err_now = 1'b1;
                res_v   = 1'b1;
                res     = '{KIND_ERROR, tsl_reg, tsc_reg, line_reg, col_reg,
                            31'd0, 8'd0, ERR_UNTERM};
            end
            else
            begin
                restart = 1'b1;
                if (mode_reg == MODE_IDENT)
                begin
                    res_v = 1'b1;
                    res   = '{KIND_IDENT, tsl_reg, tsc_reg, lastl_reg, lastc_reg,
                              31'd0, 8'd0, ERR_NONE};
                end
                else if (mode_reg == MODE_NUMBER)
                begin
                    res_v = 1'b1;
                    res   = '{KIND_INT, tsl_reg, tsc_reg, lastl_reg, lastc_reg,
                              acc_reg, 8'd0, ERR_NONE};
                end
                else if (!any_v)
                begin
                    res_v = 1'b1;
                    res   = '{KIND_NONE, '0, '0, '0, '0, 31'd0, 8'd0, ERR_NONE};
                end
            end
        end
    end

    // window shift and position update for the consumed bytes
    always_comb
    begin
        win_next   = wv >> {k, 3'b000};
        fill_next  = fv - FW'(k);
        line_next  = line_reg;
        col_next   = col_reg;
        lastl_next = lastl_reg;
        lastc_next = lastc_reg;
        if (k == 3'd1 && c == CH_LF)
        begin
            line_next  = sat_add(line_reg, 3'd1);
            col_next   = '0;
            lastl_next = line_reg;
            lastc_next = col_reg;
        end
        else if (k != 3'd0)
        begin
            col_next   = sat_add(col_reg, k);
            lastl_next = line_reg;
            lastc_next = sat_add(col_reg, k - 3'd1);
        end
    end

    assign done = drop || err_now || fin_step || (!eot_v && fill_next != FILL_FULL);

    // scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            fill_reg  <= '0;
            mode_reg  <= MODE_IDLE;
            line_reg  <= '0;
            col_reg   <= '0;
            tsl_reg   <= '0;
            tsc_reg   <= '0;
            lastl_reg <= '0;
            lastc_reg <= '0;
            acc_reg   <= '0;
            err_reg   <= 1'b0;
            act_reg   <= 1'b0;
            eot_reg   <= 1'b0;
            any_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            act_reg <= !done;
            eot_reg <= eot_v;
            any_reg <= any_v || res_v;
            if (err_now)
            begin
                err_reg  <= 1'b1;
                win_reg  <= '0;
                fill_reg <= '0;
            end
            else if (restart)
            begin
                win_reg   <= '0;
                fill_reg  <= '0;
                mode_reg  <= MODE_IDLE;
                line_reg  <= '0;
                col_reg   <= '0;
                tsl_reg   <= '0;
                tsc_reg   <= '0;
                lastl_reg <= '0;
                lastc_reg <= '0;
                acc_reg   <= '0;
            end
            else if (!drop)
            begin
                win_reg   <= win_next;
                fill_reg  <= fill_next;
                mode_reg  <= mode_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
                tsl_reg   <= tsl_next;
                tsc_reg   <= tsc_next;
                lastl_reg <= lastl_next;
                lastc_reg <= lastc_next;
                acc_reg   <= acc_next;
            end
        end
    end

    // hold stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg   <= 1'b0;
            hold_fin_reg <= 1'b0;
        end
        else if (hold_fin_reg)
        begin
            if (res_ready)
            begin
                hold_v_reg   <= 1'b0;
                hold_fin_reg <= 1'b0;
            end
        end
        else if (step_en)
        begin
            if (res_v && !done)
            begin
                hold_v_reg <= 1'b1;
            end
            else if (res_v && done)
            begin
                hold_fin_reg <= hold_v_reg;
            end
            else if (done)
            begin
                hold_v_reg <= 1'b0;
            end
        end
    end

    // hold stage payload
    always_ff @(posedge clk)
    begin
        if (!hold_fin_reg && step_en && res_v && (!done || hold_v_reg))
        begin
            hold_reg <= res;
        end
    end

    // result selection toward the output queue
    always_comb
    begin
        res_push = 1'b0;
        res_last = 1'b0;
        {res_kind, res_sl, res_sc, res_el, res_ec, res_val, res_ch, res_err} = hold_reg;
        if (hold_fin_reg)
        begin
            res_push = res_ready;
            res_last = 1'b1;
        end
        else if (step_en)
        begin
            if (hold_v_reg && (res_v || done))
            begin
                res_push = 1'b1;
                res_last = !res_v;
            end
            else if (res_v && done)
            begin
                res_push = 1'b1;
                res_last = 1'b1;
                {res_kind, res_sl, res_sc, res_el, res_ec, res_val, res_ch, res_err} = res;
            end
        end
    end
endmodule

FILE: design/source_tokenizer.sv
// source_tokenizer: top level; input queue, scanner and output queue
// depends on stok_pkg, stok_queue, stok_scan
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  source   | src_valid, src_stall | in_byte, end_of_text
//  tokens   | tok_valid, tok_stall | token_kind .. error_code, last_result
//
// one scan step per cycle unless stalled
// closing an identifier or number is its own step before the ending byte is scanned
// an item whose last step gives a result behind a held one stalls until it is pushed
// end of text flushes the window one step per cycle unless stalled, plus one close step
// asynchronous active-low reset clears all control state; no clearing pass
// two-entry queues on both sides let source and sink stall independently
module source_tokenizer #(
    parameter int POSITION_BITS = 16,
    parameter int WINDOW_DEPTH  = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     src_valid,
    output logic                     src_stall,
    input  logic [7:0]               in_byte,
    input  logic                     end_of_text,
    output logic                     tok_valid,
    input  logic                     tok_stall,
    output logic [4:0]               token_kind,
    output logic [POSITION_BITS-1:0] start_line,
    output logic [POSITION_BITS-1:0] start_column,
    output logic [POSITION_BITS-1:0] end_line,
    output logic [POSITION_BITS-1:0] end_column,
    output logic [30:0]              int_value,
    output logic [7:0]               text_char,
    output logic [1:0]               error_code,
    output logic                     last_result
);
    import stok_pkg::*;

    localparam int OW = 5 + 4 * POSITION_BITS + 31 + 8 + 2 + 1;

    logic                     iq_valid;
    logic                     iq_pop;
    logic [8:0]               iq_data;
    logic                     oq_stall;
    logic                     oq_push;
    logic [OW-1:0]            oq_data;
    logic [4:0]               r_kind;
    logic [POSITION_BITS-1:0] r_sl;
    logic [POSITION_BITS-1:0] r_sc;
    logic [POSITION_BITS-1:0] r_el;
    logic [POSITION_BITS-1:0] r_ec;
    logic [30:0]              r_val;
    logic [7:0]               r_ch;
    logic [1:0]               r_err;
    logic                     r_last;

    // front: input item queue
    stok_queue #(.W(9)) u_inq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (src_valid),
        .push_stall (src_stall),
        .push_data  ({end_of_text, in_byte}),
        .pop_valid  (iq_valid),
        .pop_stall  (!iq_pop),
        .pop_data   (iq_data)
    );

    // back: window and scanner
    stok_scan #(
        .POSITION_BITS (POSITION_BITS),
        .WINDOW_DEPTH  (WINDOW_DEPTH)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (iq_valid),
        .item_byte  (iq_data[7:0]),
        .item_eot   (iq_data[8]),
        .item_pop   (iq_pop),
        .res_ready  (!oq_stall),
        .res_push   (oq_push),
        .res_kind   (r_kind),
        .res_sl     (r_sl),
        .res_sc     (r_sc),
        .res_el     (r_el),
        .res_ec     (r_ec),
        .res_val    (r_val),
        .res_ch     (r_ch),
        .res_err    (r_err),
        .res_last   (r_last)
    );

    // result queue
    stok_queue #(.W(OW)) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (oq_push),
        .push_stall (oq_stall),
        .push_data  ({r_kind, r_sl, r_sc, r_el, r_ec, r_val, r_ch, r_err, r_last}),
        .pop_valid  (tok_valid),
        .pop_stall  (tok_stall),
        .pop_data   (oq_data)
    );

    assign {token_kind, start_line, start_column, end_line, end_column,
            int_value, text_char, error_code, last_result} = oq_data;

    // result field consistency
    a_int_only: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind != KIND_INT |-> int_value == 31'd0)
        else $error("int value on a non-integer item");

    a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code on a non-error item");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (token_kind == KIND_ERROR || token_kind == KIND_NONE) |-> last_result)
        else $error("error or none item not marked last");

    a_char_pos: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind == KIND_CHAR |->
            start_line == end_line && start_column == end_column)
        else $error("content character spans more than one position");
endmodule
